// File: src/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication violated");

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication violated");

`endif

// File: src/pdga_pkg.sv
// Shared types and constants of the Poisson disk grid acceptance block.
// No dependencies; the files that use it refer to it by scoped names.
package pdga_pkg;

   localparam int COORD_W     = 16;
   localparam int RECIP_W     = 17;
   localparam int RADIUS_W    = 35;
   localparam int PROD_W      = COORD_W + RECIP_W;
   localparam int IDX_SHIFT   = 20;
   localparam int IDX_W       = PROD_W - IDX_SHIFT;
   localparam int IDX_EXT_W   = IDX_W + 1;
   localparam int CELL_W      = 12;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int ENTRY_W     = 2 * COORD_W + 1;
   localparam int WINDOW_REACH = 2;

   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;

   localparam logic [1:0] REG_AREA_WIDTH  = 2'd0;
   localparam logic [1:0] REG_AREA_HEIGHT = 2'd1;
   localparam logic [1:0] REG_RADIUS_SQ   = 2'd2;
   localparam logic [1:0] REG_CELL_RECIP  = 2'd3;

   localparam logic [COORD_W-1:0]  AREA_WIDTH_RESET  = 16'hFFFF;
   localparam logic [COORD_W-1:0]  AREA_HEIGHT_RESET = 16'hFFFF;
   localparam logic [RADIUS_W-1:0] RADIUS_SQ_RESET   = 35'd65536;
   localparam logic [RECIP_W-1:0]  CELL_RECIP_RESET  = 17'd4096;

   typedef enum logic [2:0] {
      STATUS_ACCEPTED     = 3'd0,
      STATUS_OUTSIDE_AREA = 3'd1,
      STATUS_TOO_CLOSE    = 3'd2,
      STATUS_OUTSIDE_GRID = 3'd3,
      STATUS_CLEARED      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INDEX,
      S_CHECK,
      S_SCAN,
      S_DRAIN,
      S_CLEAR
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0]  area_width;
      logic [COORD_W-1:0]  area_height;
      logic [RADIUS_W-1:0] radius_sq;
      logic [RECIP_W-1:0]  cell_recip;
   } cfg_type;

   typedef struct packed {
      logic       load_item;
      logic       load_index;
      logic       scan_init;
      logic       scan_step;
      logic       sweep_init;
      logic       sweep_step;
      logic       write_cell;
      logic       respond;
      status_type rsp_code;
   } cmd_type;

   typedef struct packed {
      logic area_fail;
      logic grid_fail;
      logic scan_last;
      logic pipe_busy;
      logic too_close;
      logic sweep_last;
   } stat_type;

endpackage

// File: src/pdga_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pdga_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pdga_csr.sv
// Configuration registers of the grid acceptance block behind an APB-style port.
// Depends on pdga_pkg.
module pdga_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [pdga_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [pdga_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [pdga_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                 pready,
   output pdga_pkg::cfg_type                    cfg
);

   logic [1:0]                        reg_sel;
   logic                              wr_strobe;
   logic [pdga_pkg::COORD_W-1:0]      area_width_ff, area_width_in;
   logic [pdga_pkg::COORD_W-1:0]      area_height_ff, area_height_in;
   logic [pdga_pkg::RADIUS_W-1:0]     radius_sq_ff, radius_sq_in;
   logic [pdga_pkg::RECIP_W-1:0]      cell_recip_ff, cell_recip_in;

   // Registers sit on 8-byte boundaries.
   assign reg_sel   = paddr[4:3];
   assign wr_strobe = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_comb begin
      area_width_in  = area_width_ff;
      area_height_in = area_height_ff;
      radius_sq_in   = radius_sq_ff;
      cell_recip_in  = cell_recip_ff;
      if (wr_strobe) begin
         case (reg_sel)
            pdga_pkg::REG_AREA_WIDTH: begin
               area_width_in = pwdata[pdga_pkg::COORD_W-1:0];
            end
            pdga_pkg::REG_AREA_HEIGHT: begin
               area_height_in = pwdata[pdga_pkg::COORD_W-1:0];
            end
            pdga_pkg::REG_RADIUS_SQ: begin
               radius_sq_in = pwdata[pdga_pkg::RADIUS_W-1:0];
            end
            pdga_pkg::REG_CELL_RECIP: begin
               cell_recip_in = pwdata[pdga_pkg::RECIP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_width_ff  <= pdga_pkg::AREA_WIDTH_RESET;
         area_height_ff <= pdga_pkg::AREA_HEIGHT_RESET;
         radius_sq_ff   <= pdga_pkg::RADIUS_SQ_RESET;
         cell_recip_ff  <= pdga_pkg::CELL_RECIP_RESET;
      end else begin
         area_width_ff  <= area_width_in;
         area_height_ff <= area_height_in;
         radius_sq_ff   <= radius_sq_in;
         cell_recip_ff  <= cell_recip_in;
      end
   end

   always_comb begin
      case (reg_sel)
         pdga_pkg::REG_AREA_WIDTH:  prdata = pdga_pkg::CSR_DATA_W'(area_width_ff);
         pdga_pkg::REG_AREA_HEIGHT: prdata = pdga_pkg::CSR_DATA_W'(area_height_ff);
         pdga_pkg::REG_RADIUS_SQ:   prdata = pdga_pkg::CSR_DATA_W'(radius_sq_ff);
         pdga_pkg::REG_CELL_RECIP:  prdata = pdga_pkg::CSR_DATA_W'(cell_recip_ff);
         default:                   prdata = '0;
      endcase
   end

   assign cfg.area_width  = area_width_ff;
   assign cfg.area_height = area_height_ff;
   assign cfg.radius_sq   = radius_sq_ff;
   assign cfg.cell_recip  = cell_recip_ff;

endmodule

// File: src/pdga_ctrl.sv
// Sequencing state machine of the grid acceptance block.
// Depends on pdga_pkg; drives the datapath through cmd_type, reads stat_type.
module pdga_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               req_type,
   output logic               busy,
   output pdga_pkg::cmd_type  cmd,
   input  pdga_pkg::stat_type stat
);

   pdga_pkg::state_type state_ff, state_in;
   logic                clr_resp_ff, clr_resp_in;
   logic                accept;

   assign accept = start && (state_ff == pdga_pkg::S_IDLE);

   // Next state.
   always_comb begin
      state_in    = state_ff;
      clr_resp_in = clr_resp_ff;
      case (state_ff)
         pdga_pkg::S_IDLE: begin
            if (accept) begin
               clr_resp_in = req_type;
               state_in    = req_type ? pdga_pkg::S_CLEAR : pdga_pkg::S_INDEX;
            end
         end
         pdga_pkg::S_INDEX: begin
            state_in = pdga_pkg::S_CHECK;
         end
         pdga_pkg::S_CHECK: begin
            if (stat.area_fail || stat.grid_fail) begin
               state_in = pdga_pkg::S_IDLE;
            end else begin
               state_in = pdga_pkg::S_SCAN;
            end
         end
         pdga_pkg::S_SCAN: begin
            if (stat.scan_last) begin
               state_in = pdga_pkg::S_DRAIN;
            end
         end
         pdga_pkg::S_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = pdga_pkg::S_IDLE;
            end
         end
         pdga_pkg::S_CLEAR: begin
            if (stat.sweep_last) begin
               state_in = pdga_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pdga_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd.load_item  = 1'b0;
      cmd.load_index = 1'b0;
      cmd.scan_init  = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.sweep_init = 1'b0;
      cmd.sweep_step = 1'b0;
      cmd.write_cell = 1'b0;
      cmd.respond    = 1'b0;
      cmd.rsp_code   = pdga_pkg::STATUS_ACCEPTED;
      busy           = 1'b1;
      case (state_ff)
         pdga_pkg::S_IDLE: begin
            busy = 1'b0;
            if (accept) begin
               cmd.load_item  = 1'b1;
               cmd.sweep_init = req_type;
            end
         end
         pdga_pkg::S_INDEX: begin
            cmd.load_index = 1'b1;
         end
         pdga_pkg::S_CHECK: begin
            if (stat.area_fail) begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = pdga_pkg::STATUS_OUTSIDE_AREA;
            end else if (stat.grid_fail) begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = pdga_pkg::STATUS_OUTSIDE_GRID;
            end else begin
               cmd.scan_init = 1'b1;
            end
         end
         pdga_pkg::S_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         pdga_pkg::S_DRAIN: begin
            if (!stat.pipe_busy) begin
               cmd.respond    = 1'b1;
               cmd.write_cell = !stat.too_close;
               cmd.rsp_code   = stat.too_close ? pdga_pkg::STATUS_TOO_CLOSE
                                               : pdga_pkg::STATUS_ACCEPTED;
            end
         end
         pdga_pkg::S_CLEAR: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last && clr_resp_ff) begin
               cmd.respond  = 1'b1;
               cmd.rsp_code = pdga_pkg::STATUS_CLEARED;
            end
         end
         default: begin
         end
      endcase
   end

   // Reset starts with a sweep of the store that reports no result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pdga_pkg::S_CLEAR;
         clr_resp_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         clr_resp_ff <= clr_resp_in;
      end
   end

endmodule

// File: src/pdga_dp.sv
// Datapath of the grid acceptance block: cell index, window scan, distance
// pipeline, cell store and result registers. Depends on pdga_pkg and pdga_ram.
module pdga_dp #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pdga_pkg::cmd_type             cmd,
   output pdga_pkg::stat_type            stat,
   input  pdga_pkg::cfg_type             cfg,
   input  logic [pdga_pkg::COORD_W-1:0]  req_cand_x,
   input  logic [pdga_pkg::COORD_W-1:0]  req_cand_y,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [pdga_pkg::CELL_W-1:0]   rsp_cell_col,
   output logic [pdga_pkg::CELL_W-1:0]   rsp_cell_row
);

   localparam int CELLS  = GRID_COLS * GRID_ROWS;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int COL_W  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
   localparam int ROW_W  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
   localparam int CW     = pdga_pkg::COORD_W;
   localparam int XW     = pdga_pkg::IDX_EXT_W;

   localparam logic [XW-1:0]     REACH_X   = XW'(pdga_pkg::WINDOW_REACH);
   localparam logic [XW-1:0]     COL_MAX_X = XW'(GRID_COLS - 1);
   localparam logic [XW-1:0]     ROW_MAX_X = XW'(GRID_ROWS - 1);
   localparam logic [ADDR_W-1:0] ROWS_A    = ADDR_W'(GRID_ROWS);
   localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELLS - 1);

   logic [CW-1:0]                   x_ff, x_in, y_ff, y_in;
   logic [pdga_pkg::PROD_W-1:0]     prod_x, prod_y;
   logic [pdga_pkg::IDX_W-1:0]      col_full_ff, col_full_in, row_full_ff, row_full_in;
   logic [XW-1:0]                   col_ext, row_ext, col_hi, row_hi;
   logic [XW-1:0]                   c0_ext, c1_ext, r0_ext, r1_ext;
   logic [COL_W-1:0]                c0, c1, col_scan_ff, col_scan_in;
   logic [ROW_W-1:0]                r0, r1, row_scan_ff, row_scan_in;
   logic [ADDR_W-1:0]               scan_addr, own_addr;
   logic [ADDR_W-1:0]               sweep_ff, sweep_in;
   logic                            wr_en;
   logic [ADDR_W-1:0]               wr_addr;
   logic [pdga_pkg::ENTRY_W-1:0]    wr_data, rd_data;
   logic [CW-1:0]                   ent_x, ent_y, dx, dy;
   logic                            issue_ff, issue_in;
   logic                            sq_valid_ff, sq_valid_in;
   logic [pdga_pkg::SQ_W-1:0]       dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [pdga_pkg::SQ_W:0]         dist_sq;
   logic                            close_ff, close_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   pdga_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [pdga_pkg::CELL_W-1:0]     rsp_col_ff, rsp_col_in, rsp_row_ff, rsp_row_in;

   // Item capture and cell index.
   assign prod_x = pdga_pkg::PROD_W'(x_ff) * pdga_pkg::PROD_W'(cfg.cell_recip);
   assign prod_y = pdga_pkg::PROD_W'(y_ff) * pdga_pkg::PROD_W'(cfg.cell_recip);

   always_comb begin
      x_in        = cmd.load_item ? req_cand_x : x_ff;
      y_in        = cmd.load_item ? req_cand_y : y_ff;
      col_full_in = cmd.load_index ? prod_x[pdga_pkg::IDX_SHIFT +: pdga_pkg::IDX_W]
                                   : col_full_ff;
      row_full_in = cmd.load_index ? prod_y[pdga_pkg::IDX_SHIFT +: pdga_pkg::IDX_W]
                                   : row_full_ff;
   end

   assign stat.area_fail = (x_ff >= cfg.area_width) || (y_ff >= cfg.area_height);
   assign stat.grid_fail = ({1'b0, col_full_ff} > COL_MAX_X) ||
                           ({1'b0, row_full_ff} > ROW_MAX_X);

   // Window bounds, clipped to the grid.
   assign col_ext = {1'b0, col_full_ff};
   assign row_ext = {1'b0, row_full_ff};
   assign col_hi  = col_ext + REACH_X;
   assign row_hi  = row_ext + REACH_X;
   assign c0_ext  = (col_ext >= REACH_X) ? col_ext - REACH_X : '0;
   assign r0_ext  = (row_ext >= REACH_X) ? row_ext - REACH_X : '0;
   assign c1_ext  = (col_hi > COL_MAX_X) ? COL_MAX_X : col_hi;
   assign r1_ext  = (row_hi > ROW_MAX_X) ? ROW_MAX_X : row_hi;
   assign c0      = c0_ext[COL_W-1:0];
   assign c1      = c1_ext[COL_W-1:0];
   assign r0      = r0_ext[ROW_W-1:0];
   assign r1      = r1_ext[ROW_W-1:0];

   // Window scan: rows run fastest, then columns.
   always_comb begin
      col_scan_in = col_scan_ff;
      row_scan_in = row_scan_ff;
      if (cmd.scan_init) begin
         col_scan_in = c0;
         row_scan_in = r0;
      end else if (cmd.scan_step) begin
         if (row_scan_ff == r1) begin
            row_scan_in = r0;
            col_scan_in = col_scan_ff + 1'b1;
         end else begin
            row_scan_in = row_scan_ff + 1'b1;
         end
      end
   end

   assign stat.scan_last = (col_scan_ff == c1) && (row_scan_ff == r1);

   // Cell address is column * GRID_ROWS + row; the product always fits ADDR_W.
   assign scan_addr = ADDR_W'(col_scan_ff) * ROWS_A + ADDR_W'(row_scan_ff);
   assign own_addr  = ADDR_W'(col_full_ff[COL_W-1:0]) * ROWS_A
                    + ADDR_W'(row_full_ff[ROW_W-1:0]);

   // Clearing sweep.
   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.sweep_init) begin
         sweep_in = '0;
      end else if (cmd.sweep_step) begin
         sweep_in = sweep_ff + 1'b1;
      end
   end

   assign stat.sweep_last = (sweep_ff == LAST_A);

   always_comb begin
      wr_en   = cmd.sweep_step | cmd.write_cell;
      wr_addr = cmd.sweep_step ? sweep_ff : own_addr;
      wr_data = cmd.sweep_step ? '0 : {1'b1, x_ff, y_ff};
   end

   pdga_ram #(
      .WIDTH (pdga_pkg::ENTRY_W),
      .DEPTH (CELLS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (scan_addr),
      .rd_data (rd_data)
   );

   // Distance pipeline: read data, then squares, then sum and compare.
   assign ent_x = rd_data[2*CW-1:CW];
   assign ent_y = rd_data[CW-1:0];
   assign dx    = (ent_x >= x_ff) ? ent_x - x_ff : x_ff - ent_x;
   assign dy    = (ent_y >= y_ff) ? ent_y - y_ff : y_ff - ent_y;

   always_comb begin
      issue_in    = cmd.scan_step;
      sq_valid_in = issue_ff && rd_data[pdga_pkg::ENTRY_W-1];
      dx2_in      = pdga_pkg::SQ_W'(dx) * pdga_pkg::SQ_W'(dx);
      dy2_in      = pdga_pkg::SQ_W'(dy) * pdga_pkg::SQ_W'(dy);
   end

   assign dist_sq = {1'b0, dx2_ff} + {1'b0, dy2_ff};

   always_comb begin
      close_in = close_ff;
      if (cmd.scan_init) begin
         close_in = 1'b0;
      end else if (sq_valid_ff && (pdga_pkg::RADIUS_W'(dist_sq) < cfg.radius_sq)) begin
         close_in = 1'b1;
      end
   end

   assign stat.pipe_busy = issue_ff || sq_valid_ff;
   assign stat.too_close = close_ff;

   // Result registers.
   always_comb begin
      rsp_valid_in  = cmd.respond;
      rsp_status_in = rsp_status_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_row_in    = rsp_row_ff;
      if (cmd.respond) begin
         rsp_status_in = cmd.rsp_code;
         if (cmd.rsp_code == pdga_pkg::STATUS_CLEARED) begin
            rsp_col_in = '0;
            rsp_row_in = '0;
         end else begin
            rsp_col_in = col_full_ff[pdga_pkg::CELL_W-1:0];
            rsp_row_in = row_full_ff[pdga_pkg::CELL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff     <= '0;
         issue_ff     <= 1'b0;
         sq_valid_ff  <= 1'b0;
         close_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sweep_ff     <= sweep_in;
         issue_ff     <= issue_in;
         sq_valid_ff  <= sq_valid_in;
         close_ff     <= close_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      y_ff          <= y_in;
      col_full_ff   <= col_full_in;
      row_full_ff   <= row_full_in;
      col_scan_ff   <= col_scan_in;
      row_scan_ff   <= row_scan_in;
      dx2_ff        <= dx2_in;
      dy2_ff        <= dy2_in;
      rsp_status_ff <= rsp_status_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_row_ff    <= rsp_row_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_cell_col = rsp_col_ff;
   assign rsp_cell_row = rsp_row_ff;

endmodule

// File: src/poisson_disk_grid_accept.sv
// Top level of the Poisson disk grid acceptance block.
// Depends on pdga_pkg, pdga_csr, pdga_ctrl, pdga_dp and pdga_ram.
//
// Usage. A request is a transfer on the command channel: it is taken at a rising
// edge where start is high and busy is low. req_type selects a candidate test
// (req_cand_x/req_cand_y, unsigned 12.4) or a clear of the whole cell store.
// Every request produces exactly one result, shown on rsp_status, rsp_cell_col
// and rsp_cell_row for a single cycle with rsp_valid high. The receiver cannot
// stall the block: the result is taken at the edge that ends that cycle.
// A candidate test first indexes the cell, then runs the area and grid checks;
// a candidate that fails either check gets its result from the check state.
// Otherwise the window cells (up to 25) are read one per cycle from the single
// read port of the cell store, the distance pipeline drains, and the decision
// is registered as the result. A clear sweeps the store one cell per cycle.
// One request is worked on at a time; busy falls in the cycle the result is
// shown, so the next request may be taken then. After reset the block sweeps
// all GRID_COLS*GRID_ROWS cells (4096 at the default size) with busy high and
// reports no result. The user must write the configuration registers through
// the APB-style port while idle; the block itself has no guard for this.
module poisson_disk_grid_accept #(
   parameter int GRID_COLS = 64,
   parameter int GRID_ROWS = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   // Command channel.
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_type,
   input  logic [pdga_pkg::COORD_W-1:0]     req_cand_x,
   input  logic [pdga_pkg::COORD_W-1:0]     req_cand_y,
   // Result channel.
   output logic                             rsp_valid,
   output logic [2:0]                       rsp_status,
   output logic [pdga_pkg::CELL_W-1:0]      rsp_cell_col,
   output logic [pdga_pkg::CELL_W-1:0]      rsp_cell_row,
   // Configuration port.
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [pdga_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [pdga_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [pdga_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);

   pdga_pkg::cfg_type  cfg;
   pdga_pkg::cmd_type  cmd;
   pdga_pkg::stat_type stat;

   // Register bank: area limits, squared radius and the cell-size reciprocal.
   pdga_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer: index, checks, window scan, drain, decide; or a clearing sweep.
   pdga_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .busy     (busy),
      .cmd      (cmd),
      .stat     (stat)
   );

   // Arithmetic, the cell store and the result registers.
   pdga_dp #(
      .GRID_COLS (GRID_COLS),
      .GRID_ROWS (GRID_ROWS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .cfg          (cfg),
      .req_cand_x   (req_cand_x),
      .req_cand_y   (req_cand_y),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status),
      .rsp_cell_col (rsp_cell_col),
      .rsp_cell_row (rsp_cell_row)
   );

endmodule

// File: src/pdga_checker.sv
// Port-level checks of the grid acceptance block and their binding to its top.
// Depends on pdga_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pdga_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic                           rsp_valid,
   input logic [2:0]                     rsp_status,
   input logic [pdga_pkg::CELL_W-1:0]    rsp_cell_col,
   input logic [pdga_pkg::CELL_W-1:0]    rsp_cell_row
);

   logic clear_shown;
   logic cell_zero;

   assign clear_shown = rsp_valid && (rsp_status == 3'(pdga_pkg::STATUS_CLEARED));
   assign cell_zero   = (rsp_cell_col == '0) && (rsp_cell_row == '0);

   // A taken request keeps the block busy in the next cycle.
   `ASSERT_NEXT(a_busy_after_take, clock, reset, start && !busy, busy)

   // Results never come back to back: every request passes through a busy state first.
   `ASSERT_NEXT(a_no_double_result, clock, reset, rsp_valid, !rsp_valid)

   // A result is only shown once the block has returned to idle.
   `ASSERT_IMPLY(a_idle_with_result, clock, reset, rsp_valid, !busy)

   // A clear reports no cell.
   `ASSERT_IMPLY(a_clear_no_cell, clock, reset, clear_shown, cell_zero)

   // Status codes stay within the defined set.
   `ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_status <= 3'(pdga_pkg::STATUS_CLEARED))

endmodule

bind poisson_disk_grid_accept pdga_checker u_pdga_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_status   (rsp_status),
   .rsp_cell_col (rsp_cell_col),
   .rsp_cell_row (rsp_cell_row)
);
